// ===== rtl/core/rbd_pkg.sv =====
// package with widths, register codes and shared types for the reward decay block
`timescale 1ns / 1ps

package rbd_pkg;

    localparam int REWARD_WIDTH = 24;
    localparam int MAG_WIDTH    = REWARD_WIDTH - 1;
    localparam int ID_WIDTH     = 64;
    localparam int COUNT_WIDTH  = 16;
    localparam int STEP_WIDTH   = 16;
    localparam int ADDR_WIDTH   = 4;
    localparam int DATA_WIDTH   = 32;
    localparam int DIV_CNT_WIDTH = $clog2(MAG_WIDTH + 1);

    // register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_STEP_SIZE   = 2'd0;
    localparam logic [1:0] REG_REPEAT_SIZE = 2'd1;
    localparam logic [1:0] REG_MIN_ABS     = 2'd2;

    localparam logic [STEP_WIDTH-1:0]  STEP_SIZE_RST   = STEP_WIDTH'(1);
    localparam logic [COUNT_WIDTH-1:0] REPEAT_SIZE_RST = COUNT_WIDTH'(1);
    localparam logic [MAG_WIDTH-1:0]   MIN_ABS_RST     = MAG_WIDTH'(6554);
    localparam logic [MAG_WIDTH-1:0]   MAG_MAX         = {MAG_WIDTH{1'b1}};

    typedef logic [MAG_WIDTH-1:0] mag_t;

    // handshake between sequencer and divider
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== rtl/core/rbd_divider.sv =====
// serial restoring divider: magnitude over step size, one quotient bit per cycle
`timescale 1ns / 1ps

module rbd_divider (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  rbd_pkg::mag_t                 dividend,
    input  logic [rbd_pkg::STEP_WIDTH-1:0] divisor,
    output rbd_pkg::mag_t                 quotient,
    output rbd_pkg::div_stat_t            stat
);
    import rbd_pkg::*;

    logic [DIV_CNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic [STEP_WIDTH-1:0]    rem_reg, rem_next;
    logic [STEP_WIDTH-1:0]    dsr_reg, dsr_next;
    mag_t                     quo_reg, quo_next;
    logic                     done_reg, done_next;
    logic [STEP_WIDTH:0]      shifted;
    logic [STEP_WIDTH:0]      diff;
    logic                     fits;

    // one trial subtraction per step
    always_comb begin
        shifted = {rem_reg, quo_reg[MAG_WIDTH-1]};
        diff    = shifted - {1'b0, dsr_reg};
        fits    = shifted >= {1'b0, dsr_reg};
    end

    // step sequencing
    always_comb begin
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        done_next = 1'b0;
        if (start) begin
            cnt_next = DIV_CNT_WIDTH'(MAG_WIDTH);
            rem_next = '0;
            dsr_next = divisor;
            quo_next = dividend;
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - DIV_CNT_WIDTH'(1);
            rem_next = fits ? diff[STEP_WIDTH-1:0] : shifted[STEP_WIDTH-1:0];
            quo_next = {quo_reg[MAG_WIDTH-2:0], fits};
            if (cnt_reg == DIV_CNT_WIDTH'(1)) begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = cnt_reg != '0;
    assign stat.done = done_reg;

endmodule

// ===== rtl/core/reward_backpropagation_decay.sv =====
// top level: reward backpropagation with stepwise decay, apb registers and serial divide
//
// channel  | dir | fields                       | handshake
// s_       | in  | s_record_id, s_true_reward   | s_valid / s_ready
// m_       | out | m_prop_reward                | m_valid / m_ready
// apb      | in  | step_size, repeat_size, min  | psel, penable, pwrite, pready
//
// the result is computed in the cycle a transfer is taken and lands in the output register.
// a reward event then starts the 23-step divider for the decay step; the input stays
// not ready until it is done, while other records do not hold the input.
// s_ready also needs the output register empty or being taken.
// synchronous active-low reset clears the state, registers go to their reset values.
`timescale 1ns / 1ps

module reward_backpropagation_decay (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [rbd_pkg::ID_WIDTH-1:0]        s_record_id,
    input  logic signed [rbd_pkg::REWARD_WIDTH-1:0] s_true_reward,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [rbd_pkg::REWARD_WIDTH-1:0] m_prop_reward,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rbd_pkg::ADDR_WIDTH-1:0]      paddr,
    input  logic [rbd_pkg::DATA_WIDTH-1:0]      pwdata,
    output logic [rbd_pkg::DATA_WIDTH-1:0]      prdata,
    output logic                                pready
);
    import rbd_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DIV  = 1'b1;

    // configuration registers
    logic [STEP_WIDTH-1:0]  step_size_reg;
    logic [COUNT_WIDTH-1:0] repeat_size_reg;
    mag_t                   min_abs_reg;
    logic                   cfg_wr;
    logic [1:0]             cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_size_reg   <= STEP_SIZE_RST;
            repeat_size_reg <= REPEAT_SIZE_RST;
            min_abs_reg     <= MIN_ABS_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_STEP_SIZE:   step_size_reg   <= pwdata[STEP_WIDTH-1:0];
                REG_REPEAT_SIZE: repeat_size_reg <= pwdata[COUNT_WIDTH-1:0];
                REG_MIN_ABS:     min_abs_reg     <= pwdata[MAG_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (cfg_idx)
            REG_STEP_SIZE:   prdata = DATA_WIDTH'(step_size_reg);
            REG_REPEAT_SIZE: prdata = DATA_WIDTH'(repeat_size_reg);
            REG_MIN_ABS:     prdata = DATA_WIDTH'(min_abs_reg);
            default:         prdata = '0;
        endcase
    end

    // held state
    logic                   state_reg, state_next;
    logic [ID_WIDTH-1:0]    cur_id_reg;
    mag_t                   held_mag_reg, held_mag_next;
    mag_t                   decay_step_reg;
    logic                   held_neg_reg, held_neg_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic                   out_valid_reg;
    logic [REWARD_WIDTH-1:0] out_data_reg, out_data_next;

    logic                   take;
    logic                   id_match;
    mag_t                   mag_eff;
    logic [COUNT_WIDTH-1:0] cnt_eff;
    logic                   in_neg;
    logic [REWARD_WIDTH-1:0] in_mag;
    mag_t                   in_mag_sat;
    logic                   is_event;
    mag_t                   decayed;
    logic                   div_start;
    logic [STEP_WIDTH-1:0]  divisor;
    mag_t                   quotient;
    div_stat_t              div_stat;

    assign s_ready = (state_reg == ST_IDLE) && (!out_valid_reg || m_ready);
    assign take    = s_valid && s_ready;

    // magnitude of the incoming reward, event test, record match, decayed value and divisor
    always_comb begin
        in_neg     = s_true_reward[REWARD_WIDTH-1];
        in_mag     = in_neg ? (~s_true_reward + REWARD_WIDTH'(1)) : s_true_reward;
        in_mag_sat = in_mag[REWARD_WIDTH-1] ? MAG_MAX : in_mag[MAG_WIDTH-1:0];
        is_event   = in_mag >= {1'b0, min_abs_reg};
        id_match   = s_record_id == cur_id_reg;
        mag_eff    = id_match ? held_mag_reg : '0;
        cnt_eff    = id_match ? count_reg : COUNT_WIDTH'(1);
        decayed    = (decay_step_reg > mag_eff) ? '0 : mag_eff - decay_step_reg;
        divisor    = (step_size_reg == '0) ? STEP_WIDTH'(1) : step_size_reg;
    end

    // per-record update and result
    always_comb begin
        held_mag_next = mag_eff;
        held_neg_next = held_neg_reg;
        count_next    = cnt_eff;
        out_data_next = '0;
        div_start     = 1'b0;
        if (is_event) begin
            held_mag_next = in_mag_sat;
            held_neg_next = in_neg;
            count_next    = COUNT_WIDTH'(1);
            out_data_next = s_true_reward;
            div_start     = take;
        end else if (mag_eff != '0) begin
            if (cnt_eff == repeat_size_reg) begin
                held_mag_next = decayed;
                count_next    = COUNT_WIDTH'(1);
            end else begin
                count_next = cnt_eff + COUNT_WIDTH'(1);
            end
            out_data_next = held_neg_reg ? (~{1'b0, held_mag_next} + REWARD_WIDTH'(1))
                                         : {1'b0, held_mag_next};
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (div_start) state_next = ST_DIV;
            ST_DIV:  if (div_stat.done) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cur_id_reg     <= '0;
            held_mag_reg   <= '0;
            decay_step_reg <= '0;
            held_neg_reg   <= 1'b0;
            count_reg      <= COUNT_WIDTH'(1);
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (take) begin
                cur_id_reg   <= s_record_id;
                held_mag_reg <= held_mag_next;
                held_neg_reg <= held_neg_next;
                count_reg    <= count_next;
            end
            if (state_reg == ST_DIV && div_stat.done) begin
                decay_step_reg <= quotient;
            end
            // output transfer register
            if (take) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (take) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_prop_reward = out_data_reg;

    rbd_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (in_mag_sat),
        .divisor  (divisor),
        .quotient (quotient),
        .stat     (div_stat)
    );

endmodule
